// ===== src/lpbs_pkg.sv =====
`default_nettype none
package lpbs_pkg;

    localparam int STORE_BYTES_DEF  = 1024;
    localparam int MAX_ELEM_DEF     = 32;
    localparam int HEADER_DEF       = 4;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int CAP_RESET        = 1024;

    localparam int CAP_W  = 11;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_BEGIN = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BYTE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_PUSH = 2'd3;

    typedef enum logic [2:0] {
        CMD_PUSH_BEGIN,
        CMD_PUSH_BYTE,
        CMD_POP,
        CMD_PEEK,
        CMD_QUERY,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_cmd_item;

endpackage
`default_nettype wire

// ===== src/lpbs_front.sv =====
`default_nettype none
module lpbs_front
    import lpbs_pkg::*;
#(
    parameter int MAX_ELEM_BYTES = MAX_ELEM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [LEN_W-1:0]  i_elem_len,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_cmd_item              o_item
);

    localparam logic [LEN_W:0]   MAX_CMP = (LEN_W + 1)'(MAX_ELEM_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ELEM_BYTES);

    logic      r_valid;
    t_cmd_item r_item;
    t_cmd_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        case (i_req_type)
            REQ_PUSH_BEGIN: n_item.cmd = CMD_PUSH_BEGIN;
            REQ_PUSH_BYTE:  n_item.cmd = CMD_PUSH_BYTE;
            REQ_POP:        n_item.cmd = CMD_POP;
            REQ_PEEK:       n_item.cmd = CMD_PEEK;
            REQ_QUERY:      n_item.cmd = CMD_QUERY;
            default:        n_item.cmd = CMD_NOP;
        endcase
        n_item.len  = ({1'b0, i_elem_len} > MAX_CMP) ? MAX_LEN : i_elem_len;
        n_item.data = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/lpbs_queue.sv =====
`default_nettype none
module lpbs_queue
    import lpbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_cmd_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_cmd_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/lpbs_back.sv =====
`default_nettype none
module lpbs_back
    import lpbs_pkg::*;
#(
    parameter int STORE_BYTES  = STORE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd_item         i_cmd,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [STAT_W-1:0]      o_status,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic                   o_empty_flag,
    output logic                   o_full_flag
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = (AW + 1 > 12) ? AW + 1 : 12;
    localparam int SW = 8 * HEADER_BYTES;
    localparam int CW = (PW > SW) ? PW : SW;
    localparam int KW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [PW-1:0]    STORE_P  = PW'(STORE_BYTES);
    localparam logic [PW-1:0]    HDR_P    = PW'(HEADER_BYTES);
    localparam logic [KW-1:0]    K_LAST   = KW'(HEADER_BYTES - 1);
    localparam logic [CAP_W-1:0] TOP_INIT =
        CAP_W'((STORE_BYTES < CAP_RESET) ? STORE_BYTES : CAP_RESET);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HDR_WR,
        S_HDR_ISSUE,
        S_HDR_CAP,
        S_CALC,
        S_BYTE_ISSUE,
        S_BYTE_OUT,
        S_RESP
    } t_state;

    logic [BYTE_W-1:0] r_mem [STORE_BYTES];

    t_state            r_state;
    t_cmd_item         r_cmd;
    logic [CAP_W-1:0]  r_cap;
    logic [CAP_W-1:0]  r_top;
    logic              r_push_open;
    logic [LEN_W-1:0]  r_push_rem;
    logic [CAP_W-1:0]  r_push_addr;
    logic [KW-1:0]     r_k;
    logic [SW-1:0]     r_stored;
    logic [LEN_W-1:0]  r_n;
    logic [LEN_W-1:0]  r_i;
    logic [PW-1:0]     r_base;
    logic [STAT_W-1:0] r_pend_status;
    logic              r_pend_empty;
    logic              r_pend_full;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_rd_ok;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_last;
    logic              r_empty_flag;
    logic              r_full_flag;

    logic [PW-1:0]     eff;
    logic [PW-1:0]     cfg_eff;
    logic [PW-1:0]     top_p;
    logic [PW-1:0]     need;
    logic              is_empty;
    logic              is_full;
    logic              out_free;
    logic [PW-1:0]     raddr;
    logic              rd_en;
    logic [PW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic              wr_en;
    logic [BYTE_W-1:0] rd_byte;
    logic [LEN_W-1:0]  n_n;
    logic [PW-1:0]     diff;
    logic              pop_sat;
    logic [CAP_W-1:0]  n_top;

    assign eff      = (PW'(r_cap) > STORE_P) ? STORE_P : PW'(r_cap);
    assign cfg_eff  = (PW'(i_cfg_data) > STORE_P) ? STORE_P : PW'(i_cfg_data);
    assign top_p    = PW'(r_top);
    assign need     = PW'(r_cmd.len) + HDR_P;
    assign is_empty = top_p >= eff;
    assign is_full  = top_p < need;
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_byte  = r_rd_ok ? r_rdata : '0;

    // pop bounds: element running past capacity drops the top to capacity
    assign n_n     = (r_stored < SW'(r_cmd.len)) ? LEN_W'(r_stored) : r_cmd.len;
    assign diff    = eff - top_p;
    assign pop_sat = (diff < HDR_P) || (CW'(diff - HDR_P) < CW'(r_stored));
    assign n_top   = pop_sat ? CAP_W'(eff) : CAP_W'(CW'(top_p + HDR_P) + CW'(r_stored));

    assign o_cmd_ready  = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_last       = r_last;
    assign o_empty_flag = r_empty_flag;
    assign o_full_flag  = r_full_flag;

    always_comb begin
        raddr = '0;
        rd_en = 1'b0;
        waddr = '0;
        wdata = '0;
        wr_en = 1'b0;
        case (r_state)
            S_HDR_ISSUE: begin
                raddr = top_p + PW'(r_k);
                rd_en = 1'b1;
            end
            S_BYTE_ISSUE: begin
                raddr = r_base + PW'(r_i);
                rd_en = 1'b1;
            end
            S_HDR_WR: begin
                waddr = top_p + PW'(r_k);
                wdata = (r_k == '0) ? BYTE_W'(r_cmd.len) : '0;
                wr_en = 1'b1;
            end
            S_DISPATCH: begin
                waddr = PW'(r_push_addr);
                wdata = r_cmd.data;
                wr_en = (r_cmd.cmd == CMD_PUSH_BYTE) && r_push_open;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (waddr < STORE_P)) begin
            r_mem[waddr[AW-1:0]] <= wdata;
        end
        if (rd_en) begin
            r_rd_ok <= raddr < STORE_P;
        end
        if (rd_en && (raddr < STORE_P)) begin
            r_rdata <= r_mem[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_W'(CAP_RESET);
            r_top       <= TOP_INIT;
            r_push_open <= 1'b0;
            r_push_rem  <= '0;
            r_push_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_pend_status <= ST_OK;
                    r_pend_empty  <= 1'b0;
                    r_pend_full   <= 1'b0;
                    r_k           <= '0;
                    r_stored      <= '0;
                    r_state       <= S_RESP;
                    if (r_cmd.cmd != CMD_PUSH_BYTE && r_cmd.cmd != CMD_NOP) begin
                        r_push_open <= 1'b0;
                        r_push_rem  <= '0;
                    end
                    case (r_cmd.cmd)
                        CMD_PUSH_BEGIN: begin
                            if (is_full) begin
                                r_pend_status <= ST_FULL;
                            end else begin
                                r_top       <= CAP_W'(top_p - need);
                                r_push_addr <= CAP_W'(top_p - PW'(r_cmd.len));
                                r_push_rem  <= r_cmd.len;
                                r_push_open <= r_cmd.len != '0;
                                r_state     <= S_HDR_WR;
                            end
                        end
                        CMD_PUSH_BYTE: begin
                            if (!r_push_open) begin
                                r_pend_status <= ST_NO_PUSH;
                            end else begin
                                r_push_addr <= r_push_addr + 1'b1;
                                r_push_rem  <= r_push_rem - 1'b1;
                                if (r_push_rem == LEN_W'(1)) begin
                                    r_push_open <= 1'b0;
                                end
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (is_empty) begin
                                r_pend_status <= ST_EMPTY;
                            end else begin
                                r_state <= S_HDR_ISSUE;
                            end
                        end
                        CMD_QUERY: begin
                            r_pend_empty <= is_empty;
                            r_pend_full  <= is_full;
                        end
                        default: begin
                        end
                    endcase
                end
                S_HDR_WR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_RESP;
                    end
                end
                S_HDR_ISSUE: begin
                    r_state <= S_HDR_CAP;
                end
                S_HDR_CAP: begin
                    r_stored[r_k*8 +: 8] <= rd_byte;
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == K_LAST) ? S_CALC : S_HDR_ISSUE;
                end
                S_CALC: begin
                    r_base <= top_p + HDR_P;
                    r_n    <= n_n;
                    r_i    <= '0;
                    if (r_cmd.cmd == CMD_POP) begin
                        r_top <= n_top;
                    end
                    r_state <= (n_n == '0) ? S_RESP : S_BYTE_ISSUE;
                end
                S_BYTE_ISSUE: begin
                    r_state <= S_BYTE_OUT;
                end
                S_BYTE_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_status     <= ST_OK;
                        r_out_byte   <= rd_byte;
                        r_byte_valid <= 1'b1;
                        r_last       <= r_i == r_n - 1'b1;
                        r_empty_flag <= 1'b0;
                        r_full_flag  <= 1'b0;
                        r_i          <= r_i + 1'b1;
                        r_state      <= (r_i == r_n - 1'b1) ? S_IDLE : S_BYTE_ISSUE;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_status     <= r_pend_status;
                        r_out_byte   <= '0;
                        r_byte_valid <= 1'b0;
                        r_last       <= 1'b1;
                        r_empty_flag <= r_pend_empty;
                        r_full_flag  <= r_pend_full;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                r_cap       <= i_cfg_data;
                r_top       <= CAP_W'(cfg_eff);
                r_push_open <= 1'b0;
                r_push_rem  <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/length_prefixed_byte_stack.sv =====
`default_nettype none
// Stack of variable-length byte elements in a single-port byte memory, growing down from
// the capacity register; each element sits above a HEADER_BYTES little-endian length.
// Requests enter a decode register and a short queue, and a sequencer runs them against
// the memory. Push begin writes one header byte per cycle. Pop and peek read every header
// and payload byte from the memory with registered data, issuing each read in one state
// and consuming it in the next. Writing the capacity register empties the stack and drops
// any open push.
module length_prefixed_byte_stack
    import lpbs_pkg::*;
#(
    parameter int STORE_BYTES    = STORE_BYTES_DEF,
    parameter int MAX_ELEM_BYTES = MAX_ELEM_DEF,
    parameter int HEADER_BYTES   = HEADER_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [15:0]       i_s_tdata,   // elem_len[5:0], data_byte[13:6], zero
    input  wire logic [REQ_W-1:0]  i_s_tuser,   // req_type[2:0]
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [15:0]            o_m_tdata,   // status[1:0], out_byte[9:2],
                                                // empty_flag[10], full_flag[11], zero
    output logic                   o_m_tuser,   // byte_valid
    output logic                   o_m_tlast
);

    logic              f_valid;
    logic              f_ready;
    t_cmd_item         f_item;
    logic              q_valid;
    logic              q_ready;
    t_cmd_item         q_item;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              empty_flag;
    logic              full_flag;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {4'b0, full_flag, empty_flag, out_byte, status};

    lpbs_front #(
        .MAX_ELEM_BYTES(MAX_ELEM_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_req_type  (i_s_tuser),
        .i_elem_len  (i_s_tdata[5:0]),
        .i_data_byte (i_s_tdata[13:6]),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_item      (f_item)
    );

    lpbs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    lpbs_back #(
        .STORE_BYTES  (STORE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (q_valid),
        .o_cmd_ready  (q_ready),
        .i_cmd        (q_item),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_status     (status),
        .o_out_byte   (out_byte),
        .o_byte_valid (o_m_tuser),
        .o_last       (o_m_tlast),
        .o_empty_flag (empty_flag),
        .o_full_flag  (full_flag)
    );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
import lpbs_pkg::*;

typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              last;
    logic              empty_flag;
    logic              full_flag;
} t_stack_result;

class stack_scoreboard;
    int unsigned   capacity;
    int unsigned   top;
    int unsigned   push_addr;
    int unsigned   push_left;
    bit            push_open;
    logic [7:0]    mem [STORE_BYTES_DEF];
    bit            written [STORE_BYTES_DEF];
    t_stack_result expected_q [$];
    int            errors;

    function new();
        set_capacity(CAP_RESET);
        push_addr = 0;
        errors = 0;
    endfunction

    function int unsigned eff_cap();
        return (capacity > STORE_BYTES_DEF) ? STORE_BYTES_DEF : capacity;
    endfunction

    function void set_capacity(int unsigned cap);
        capacity = cap;
        top = eff_cap();
        push_open = 0;
        push_left = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void queue_result(logic [STAT_W-1:0] st, logic [7:0] b, logic v, logic l,
                               logic e, logic f);
        t_stack_result r;
        r.status = st;
        r.out_byte = b;
        r.byte_valid = v;
        r.last = l;
        r.empty_flag = e;
        r.full_flag = f;
        expected_q.push_back(r);
    endfunction

    function int unsigned stored_length();
        int unsigned n;
        n = 0;
        for (int i = 0; i < HEADER_DEF; i++)
            n |= int'(mem[top + i]) << (8 * i);
        return n;
    endfunction

    // shrink a pop/peek buffer so that no never-written payload byte gets read
    function logic [LEN_W-1:0] safe_buffer(logic [LEN_W-1:0] buf_len);
        int unsigned n;
        int unsigned k;
        if (top >= eff_cap())
            return buf_len;
        n = stored_length();
        if (buf_len < n)
            n = buf_len;
        if (n > MAX_ELEM_DEF)
            n = MAX_ELEM_DEF;
        k = 0;
        while (k < n && written[top + HEADER_DEF + k])
            k++;
        return (k < n) ? LEN_W'(k) : buf_len;
    endfunction

    function void read_element(int unsigned buf_len, bit remove);
        int unsigned cap;
        int unsigned stored;
        int unsigned n;
        int unsigned base;
        cap = eff_cap();
        if (top >= cap) begin
            queue_result(ST_EMPTY, 0, 0, 1, 0, 0);
            return;
        end
        stored = stored_length();
        n = (stored < buf_len) ? stored : buf_len;
        base = top + HEADER_DEF;
        if (n == 0)
            queue_result(ST_OK, 0, 0, 1, 0, 0);
        for (int unsigned i = 0; i < n; i++)
            queue_result(ST_OK, (base + i < STORE_BYTES_DEF) ? mem[base + i] : 8'h00, 1,
                         (i + 1 == n), 0, 0);
        if (remove) begin
            if (cap - top < HEADER_DEF || cap - top - HEADER_DEF < stored)
                top = cap;
            else
                top = base + stored;
        end
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [LEN_W-1:0] len_in,
                               logic [7:0] data);
        int unsigned len;
        len = (len_in > MAX_ELEM_DEF) ? MAX_ELEM_DEF : len_in;
        if (req == REQ_PUSH_BYTE) begin
            if (!push_open) begin
                queue_result(ST_NO_PUSH, 0, 0, 1, 0, 0);
                return;
            end
            if (push_addr < STORE_BYTES_DEF) begin
                mem[push_addr] = data;
                written[push_addr] = 1;
            end
            push_addr++;
            push_left--;
            if (push_left == 0)
                push_open = 0;
            queue_result(ST_OK, 0, 0, 1, 0, 0);
            return;
        end
        if (req > REQ_QUERY) begin
            queue_result(ST_OK, 0, 0, 1, 0, 0);
            return;
        end
        push_open = 0;
        push_left = 0;
        case (req)
            REQ_PUSH_BEGIN: begin
                if (top < len + HEADER_DEF) begin
                    queue_result(ST_FULL, 0, 0, 1, 0, 0);
                end else begin
                    top -= len + HEADER_DEF;
                    for (int i = 0; i < HEADER_DEF; i++) begin
                        if (top + i < STORE_BYTES_DEF) begin
                            mem[top + i] = 8'(len >> (8 * i));
                            written[top + i] = 1;
                        end
                    end
                    push_addr = top + HEADER_DEF;
                    push_left = len;
                    push_open = (len != 0);
                    queue_result(ST_OK, 0, 0, 1, 0, 0);
                end
            end
            REQ_POP:  read_element(len, 1);
            REQ_PEEK: read_element(len, 0);
            default:  queue_result(ST_OK, 0, 0, 1, top >= eff_cap(), top < len + HEADER_DEF);
        endcase
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", what);
    endtask

    task check_result(logic [15:0] tdata, logic byte_valid, logic last);
        t_stack_result want;
        if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected, tdata=%h", tdata));
            return;
        end
        want = expected_q.pop_front();
        if (tdata[1:0] !== want.status)
            report($sformatf("status %0d, want %0d", tdata[1:0], want.status));
        if (tdata[9:2] !== want.out_byte)
            report($sformatf("out_byte %h, want %h", tdata[9:2], want.out_byte));
        if (byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %b, want %b", byte_valid, want.byte_valid));
        if (last !== want.last)
            report($sformatf("last %b, want %b", last, want.last));
        if (tdata[10] !== want.empty_flag)
            report($sformatf("empty_flag %b, want %b", tdata[10], want.empty_flag));
        if (tdata[11] !== want.full_flag)
            report($sformatf("full_flag %b, want %b", tdata[11], want.full_flag));
    endtask
endclass

module tb;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MIN = REQ_QUERY + 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MAX = 3'd7;

    logic             i_clk = 0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [15:0]      i_s_tdata;
    logic [REQ_W-1:0] i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [15:0]      o_m_tdata;
    logic             o_m_tuser;
    logic             o_m_tlast;

    stack_scoreboard  sb;
    int               items_sent;
    bit               sender_burst;
    bit               receiver_burst;
    bit               hold_request;

    length_prefixed_byte_stack dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(i_s_tuser, i_s_tdata[5:0], i_s_tdata[13:6]);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        i_m_tready = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                i_m_tready <= 0;
                repeat (400) @(negedge i_clk);
            end
            gap = receiver_burst ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                i_m_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk);
            while (!o_m_tvalid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [LEN_W-1:0] len,
                             input logic [7:0] data);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= req;
        i_s_tdata  <= {2'b00, data, len};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input int unsigned cap);
        i_cfg_valid <= 1;
        i_cfg_data  <= CAP_W'(cap);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.set_capacity(cap);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return LEN_W'($urandom_range(MAX_ELEM_DEF + 1, 63));
        if (r < 45)
            return LEN_W'($urandom_range(0, 3));
        return LEN_W'($urandom_range(0, MAX_ELEM_DEF));
    endfunction

    task automatic run_directed();
        send_item(REQ_QUERY, 0, 8'h00);
        send_item(REQ_POP, 5, 8'h00);
        send_item(REQ_PEEK, 63, 8'hFF);
        send_item(REQ_PUSH_BYTE, 6'h3F, 8'hFF);
        send_item(REQ_UNUSED_MAX, 6'h3F, 8'hFF);
        send_item(REQ_UNUSED_MIN, 0, 8'h00);
        // zero-length element: nothing to copy, pop still removes it
        send_item(REQ_PUSH_BEGIN, 0, 8'h00);
        send_item(REQ_PEEK, 5, 8'h00);
        send_item(REQ_POP, 0, 8'h00);
        send_item(REQ_PUSH_BEGIN, 3, 8'h00);
        send_item(REQ_PUSH_BYTE, 0, 8'h00);
        send_item(REQ_PUSH_BYTE, 6'h3F, 8'hFF);
        send_item(REQ_PUSH_BYTE, 6'h15, 8'hA5);
        send_item(REQ_PEEK, 63, 8'h00);
        send_item(REQ_POP, 2, 8'h00);
        send_item(REQ_QUERY, 63, 8'h00);
        // push abandoned after one byte
        send_item(REQ_PUSH_BEGIN, 4, 8'h00);
        send_item(REQ_PUSH_BYTE, 0, 8'h5A);
        send_item(REQ_QUERY, 0, 8'h00);
        send_item(REQ_POP, sb.safe_buffer(63), 8'h00);
        // oversized length saturates
        send_item(REQ_PUSH_BEGIN, 40, 8'h00);
        send_item(REQ_PEEK, 0, 8'h00);
        send_item(REQ_POP, sb.safe_buffer(63), 8'h00);
    endtask

    task automatic run_random(input int goal);
        int sel;
        int nbytes;
        logic [LEN_W-1:0] len;
        while (items_sent < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                len = pick_len();
                send_item(REQ_PUSH_BEGIN, len, 8'($urandom));
                nbytes = sb.push_open ? sb.push_left : 0;
                if ($urandom_range(0, 9) == 0)
                    nbytes = $urandom_range(0, nbytes);
                repeat (nbytes) send_item(REQ_PUSH_BYTE, LEN_W'($urandom), 8'($urandom));
            end else if (sel < 60) begin
                send_item(REQ_POP, sb.safe_buffer(pick_len()), 8'($urandom));
            end else if (sel < 75) begin
                send_item(REQ_PEEK, sb.safe_buffer(pick_len()), 8'($urandom));
            end else if (sel < 87) begin
                send_item(REQ_QUERY, pick_len(), 8'($urandom));
            end else if (sel < 94) begin
                send_item(REQ_PUSH_BYTE, LEN_W'($urandom), 8'($urandom));
            end else begin
                send_item(REQ_W'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX)),
                          LEN_W'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned phase_caps [7];
        sb = new();
        items_sent = 0;
        sender_burst = 0;
        receiver_burst = 0;
        hold_request = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        phase_caps = '{4, 2047, 64, 0, 37, 1024, 1024};
        phase_caps[5] = $urandom_range(4, 1024);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        run_directed();
        drain();
        for (int p = 0; p < 7; p++) begin
            write_capacity(phase_caps[p]);
            sender_burst   = (p % 3 == 1) || (p == 2);
            receiver_burst = (p % 3 == 1);
            if (p == 2)
                hold_request = 1;
            run_random(items_sent + 62);
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end
endmodule
